// ===== design/bounded_membership_set_unit_macros.svh =====
// Assertion macros used by the checker file.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef BOUNDED_MEMBERSHIP_SET_UNIT_MACROS_SVH
`define BOUNDED_MEMBERSHIP_SET_UNIT_MACROS_SVH

// Same-cycle implication.
`define BMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bms: same-cycle check failed");

// Next-cycle implication.
`define BMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bms: next-cycle check failed");

`endif

// ===== design/bms_pkg.sv =====
// ----------------------------------------------------------------------------
// bms_pkg
// Types and constants shared by the membership set unit.
// ----------------------------------------------------------------------------
package bms_pkg;

	localparam int IN_VALUE_BITS = 32;
	localparam int RES_BITS      = 5;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] OPC_LOOKUP = 2'd0;
	localparam logic [1:0] OPC_INSERT = 2'd1;
	localparam logic [1:0] OPC_REMOVE = 2'd2;

	typedef enum logic [1:0] {
		CMD_LOOKUP,
		CMD_INSERT,
		CMD_REMOVE
	} cmd_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic [IN_VALUE_BITS-1:0] key;
	} work_t;

endpackage

// ===== design/bms_if.sv =====
// ----------------------------------------------------------------------------
// bms_req_if / bms_rsp_if
// Valid/ready channels for requests into and results out of the set unit.
// ----------------------------------------------------------------------------
interface bms_req_if import bms_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [1:0]               opcode;
	logic [IN_VALUE_BITS-1:0] value;

	modport source(output valid, opcode, value, input ready);
	modport sink(input valid, opcode, value, output ready);
endinterface

interface bms_rsp_if import bms_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                found;
	logic [RES_BITS-1:0] position;
	logic [RES_BITS-1:0] count;
	logic                full_error;

	modport source(output valid, found, position, count, full_error, input ready);
	modport sink(input valid, found, position, count, full_error, output ready);
endinterface

// ===== design/bms_front.sv =====
// ----------------------------------------------------------------------------
// bms_front
// Accepts request items, decodes the opcode into a command and masks the value.
// ----------------------------------------------------------------------------
module bms_front import bms_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	bms_req_if.sink req,
	output logic    push_valid,
	input  logic    push_ready,
	output work_t   push_item
);

	localparam int KEEP_BITS = (VALUE_BITS < IN_VALUE_BITS) ? VALUE_BITS : IN_VALUE_BITS;
	localparam logic [IN_VALUE_BITS-1:0] KEY_MASK =
		{IN_VALUE_BITS{1'b1}} >> (IN_VALUE_BITS - KEEP_BITS);

	always_comb begin
		push_item.key = req.value & KEY_MASK;
		case (req.opcode)
			OPC_LOOKUP: push_item.cmd = CMD_LOOKUP;
			OPC_INSERT: push_item.cmd = CMD_INSERT;
			OPC_REMOVE: push_item.cmd = CMD_REMOVE;
			// unused opcode behaves as a lookup
			default:    push_item.cmd = CMD_LOOKUP;
		endcase
	end

	assign push_valid = req.valid;
	assign req.ready  = push_ready;

endmodule

// ===== design/bms_queue.sv =====
// ----------------------------------------------------------------------------
// bms_queue
// Short FIFO of decoded items between the front and the back.
// ----------------------------------------------------------------------------
module bms_queue import bms_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  work_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output work_t pop_item
);

	work_t                slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   fill_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = (fill_q != (QPTR_BITS + 1)'(QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) fill_q <= fill_q + 1'b1;
			else if (do_pop && !do_push) fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_item;
	end

endmodule

// ===== design/bms_back.sv =====
// ----------------------------------------------------------------------------
// bms_back
// Scans the entry store one slot per cycle, applies insert or swap-remove,
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module bms_back import bms_pkg::*; #(
	parameter int CAPACITY_ENTRIES = 16,
	parameter int VALUE_BITS       = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pop_valid,
	output logic      pop_ready,
	input  work_t     pop_item,
	bms_rsp_if.source rsp
);

	localparam int KEY_BITS = (VALUE_BITS < IN_VALUE_BITS) ? VALUE_BITS : IN_VALUE_BITS;
	localparam int IDX_BITS = (CAPACITY_ENTRIES > 1) ? $clog2(CAPACITY_ENTRIES) : 1;
	localparam int CNT_BITS = $clog2(CAPACITY_ENTRIES + 1);
	localparam logic [CNT_BITS-1:0] CAP_COUNT = CNT_BITS'(CAPACITY_ENTRIES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MOVE,
		ST_FINISH
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic                hit_q;
	logic [CNT_BITS-1:0] pos_q;
	logic [IDX_BITS-1:0] scan_q;
	logic [CNT_BITS-1:0] count_q;
	logic [KEY_BITS-1:0] rdata_q;
	logic [KEY_BITS-1:0] entry_store_q [CAPACITY_ENTRIES];

	logic                valid_q;
	logic                found_q;
	logic [RES_BITS-1:0] position_q;
	logic [RES_BITS-1:0] count_out_q;
	logic                full_error_q;

	logic [IDX_BITS-1:0] last_idx;
	logic [IDX_BITS-1:0] rd_addr;
	logic                match;
	logic                fin_go;
	logic                ins_ok;
	logic                full_err;
	logic [CNT_BITS-1:0] count_next;
	logic                mem_we;
	logic [IDX_BITS-1:0] mem_waddr;
	logic [KEY_BITS-1:0] mem_wdata;

	assign last_idx  = IDX_BITS'(count_q - 1'b1);
	assign match     = (rdata_q == key_q);
	assign fin_go    = !valid_q || rsp.ready;
	assign ins_ok    = (cmd_q == CMD_INSERT) && !hit_q && (count_q != CAP_COUNT);
	assign full_err  = (cmd_q == CMD_INSERT) && !hit_q && (count_q == CAP_COUNT);
	assign pop_ready = (state_q == ST_IDLE);

	always_comb begin
		if (ins_ok)                              count_next = count_q + 1'b1;
		else if (cmd_q == CMD_REMOVE && hit_q)   count_next = count_q - 1'b1;
		else                                     count_next = count_q;
	end

	// next read: slot 0 on pickup, next slot while scanning, last slot for a remove
	always_comb begin
		case (state_q)
			ST_IDLE: rd_addr = '0;
			ST_SCAN: rd_addr = (match && cmd_q == CMD_REMOVE) ? last_idx : scan_q + 1'b1;
			default: rd_addr = last_idx;
		endcase
	end

	always_comb begin
		mem_we    = (state_q == ST_MOVE) || (state_q == ST_FINISH && fin_go && ins_ok);
		mem_waddr = (state_q == ST_MOVE) ? IDX_BITS'(pos_q) : IDX_BITS'(count_q);
		mem_wdata = (state_q == ST_MOVE) ? rdata_q : key_q;
	end

	always_ff @(posedge clk) begin
		rdata_q <= entry_store_q[rd_addr];
		if (mem_we) entry_store_q[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			// in finish a taken result is replaced by the next one below
			if (valid_q && rsp.ready && state_q != ST_FINISH) valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						cmd_q  <= pop_item.cmd;
						key_q  <= KEY_BITS'(pop_item.key);
						scan_q <= '0;
						if (count_q == '0) begin
							hit_q   <= 1'b0;
							pos_q   <= count_q;
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (match) begin
						hit_q   <= 1'b1;
						pos_q   <= CNT_BITS'(scan_q);
						state_q <= (cmd_q == CMD_REMOVE) ? ST_MOVE : ST_FINISH;
					end else if (scan_q == last_idx) begin
						hit_q   <= 1'b0;
						pos_q   <= count_q;
						state_q <= ST_FINISH;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_MOVE: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					// hold until the output register is free
					if (fin_go) begin
						valid_q      <= 1'b1;
						found_q      <= hit_q;
						position_q   <= RES_BITS'(pos_q);
						count_out_q  <= RES_BITS'(count_next);
						full_error_q <= full_err;
						count_q      <= count_next;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid      = valid_q;
	assign rsp.found      = found_q;
	assign rsp.position   = position_q;
	assign rsp.count      = count_out_q;
	assign rsp.full_error = full_error_q;

endmodule

// ===== design/bounded_membership_set_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_membership_set_unit
// Set of distinct values with lookup, insert and swap-remove.
// ----------------------------------------------------------------------------
// Requests enter on req (opcode, value); each gives one result on rsp
// (found, position, count, full_error). Both are valid/ready channels.
// The front decodes a request and drops it into a two-entry queue, so req
// keeps flowing while the back is busy scanning.
// The back reads one stored entry per cycle from the entry memory: a request
// is picked up, scanned slot by slot (up to the current count), moved for a
// remove that hits, and finished. The back takes no new item until it has
// finished the last one, so that scan sets the sustained rate.
// Reset empties the set and the queue; the memory is not cleared, since only
// slots below the count are ever compared or moved.
// A stalled rsp holds its result; the back waits with the next finished
// item, and req stalls once the queue is full.
// ----------------------------------------------------------------------------
module bounded_membership_set_unit import bms_pkg::*; #(
	parameter int CAPACITY_ENTRIES = 16,
	parameter int VALUE_BITS       = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	bms_req_if.sink   req,
	bms_rsp_if.source rsp
);

	logic  push_valid;
	logic  push_ready;
	work_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	work_t pop_item;

	bms_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.req       (req),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item)
	);

	bms_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item)
	);

	bms_back #(
		.CAPACITY_ENTRIES(CAPACITY_ENTRIES),
		.VALUE_BITS      (VALUE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item (pop_item),
		.rsp      (rsp)
	);

endmodule

// ===== design/bms_checker.sv =====
// ----------------------------------------------------------------------------
// bms_checker
// Port-level checks on the result channel of the membership set unit.
// ----------------------------------------------------------------------------
`include "bounded_membership_set_unit_macros.svh"

module bms_checker import bms_pkg::*; #(
	parameter int CAPACITY_ENTRIES = 16
) (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic                rsp_found,
	input logic [RES_BITS-1:0] rsp_position,
	input logic [RES_BITS-1:0] rsp_count,
	input logic                rsp_full_error
);

	localparam logic [RES_BITS-1:0] CAP_SHOWN = RES_BITS'(CAPACITY_ENTRIES);

	`BMS_ASSERT_NEXT(a_rsp_valid_holds, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)

	`BMS_ASSERT_IMPLY(a_full_error_when_full, clk, arst_n, rsp_valid && rsp_full_error, !rsp_found && rsp_count == CAP_SHOWN)

	`BMS_ASSERT_IMPLY(a_miss_count, clk, arst_n, rsp_valid && !rsp_found, rsp_count == rsp_position || rsp_count == RES_BITS'(rsp_position + 1'b1))

	`BMS_ASSERT_IMPLY(a_hit_no_growth, clk, arst_n, rsp_valid && rsp_found, !rsp_full_error && rsp_position != CAP_SHOWN)

endmodule

bind bounded_membership_set_unit bms_checker #(
	.CAPACITY_ENTRIES(CAPACITY_ENTRIES)
) u_bms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_found     (rsp.found),
	.rsp_position  (rsp.position),
	.rsp_count     (rsp.count),
	.rsp_full_error(rsp.full_error)
);
